FILE: rtl/bok_pkg.sv
// ----------------------------------------------------------------------------
// bok_pkg
// Shared types, sizes and helper functions of the balanced ordered key set.
// ----------------------------------------------------------------------------
package bok_pkg;

  localparam int CAPACITY = 256;
  localparam int KEY_BITS = 32;

  // Node index into the store, and a link that can also hold the null value.
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int LINK_W = $clog2(CAPACITY + 1);
  localparam int COUNT_W = LINK_W;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);

  // A height-balanced tree of CAPACITY nodes is far shallower than this.
  localparam int PATH_DEPTH = 2 * IDX_W;
  localparam int PATH_IDX_W = $clog2(PATH_DEPTH);
  localparam int PATH_SP_W  = $clog2(PATH_DEPTH + 1);
  localparam int HGT_W      = $clog2(PATH_DEPTH + 1);

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [LINK_W-1:0]   left;
    logic [LINK_W-1:0]   right;
    logic [HGT_W-1:0]    height;
  } node_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DESC,
    ST_DESC_W,
    ST_REM,
    ST_PRED,
    ST_PRED_W,
    ST_ALLOC,
    ST_ALLOC_W,
    ST_ALLOC_WR,
    ST_UP,
    ST_UP_X,
    ST_UP_O,
    ST_RB_Y,
    ST_RB_YO,
    ST_RB_YI,
    ST_RB_S1,
    ST_RB_S2,
    ST_RB_ZA,
    ST_RB_ZB,
    ST_RB_D1,
    ST_RB_D2,
    ST_RB_D3,
    ST_FIN
  } state_t;

  function automatic logic [LINK_W-1:0] child_of(node_t n, logic side);
    return side ? n.right : n.left;
  endfunction

  // Store address behind a child link. A null link gives an address whose
  // contents are never used.
  function automatic logic [IDX_W-1:0] child_addr(node_t n, logic side);
    logic [LINK_W-1:0] l;
    l = side ? n.right : n.left;
    return l[IDX_W-1:0];
  endfunction

  function automatic node_t with_child(node_t n, logic side, logic [LINK_W-1:0] l);
    node_t r;
    r = n;
    if (side) begin
      r.right = l;
    end else begin
      r.left = l;
    end
    return r;
  endfunction

  // Height of the subtree behind a link; n is the record read at that link.
  function automatic logic [HGT_W-1:0] hgt_of(logic [LINK_W-1:0] l, node_t n);
    return (l == NULL_LINK) ? '0 : n.height;
  endfunction

  function automatic logic [HGT_W-1:0] hnext(logic [HGT_W-1:0] a, logic [HGT_W-1:0] b);
    logic [HGT_W-1:0] m;
    m = (a > b) ? a : b;
    return m + 1'b1;
  endfunction

endpackage

FILE: rtl/bok_req_if.sv
// ----------------------------------------------------------------------------
// bok_req_if
// Request channel: one action and one key per transaction.
// ----------------------------------------------------------------------------
interface bok_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          action;
  logic signed [bok_pkg::KEY_BITS-1:0] key;

  modport source(output valid, action, key, input ready);
  modport sink(input valid, action, key, output ready);
endinterface

FILE: rtl/bok_rsp_if.sv
// ----------------------------------------------------------------------------
// bok_rsp_if
// Response channel: status flags and element count per transaction.
// ----------------------------------------------------------------------------
interface bok_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         was_present;
  logic                         changed;
  logic                         full_refused;
  logic [bok_pkg::COUNT_W-1:0]  element_count;

  modport source(output valid, was_present, changed, full_refused, element_count,
                 input ready);
  modport sink(input valid, was_present, changed, full_refused, element_count,
               output ready);
endinterface

FILE: rtl/balanced_ordered_key_set.sv
// ----------------------------------------------------------------------------
// balanced_ordered_key_set
// Set of distinct signed keys kept in a height-balanced search tree.
// ----------------------------------------------------------------------------
// Usage:
//   Each request transaction on req carries an action (insert, remove, or
//   test; both unused codes test) and a signed key. Each request yields one
//   response transaction on rsp with was_present, changed, full_refused and
//   the element count after the request.
//   Requests are taken one at a time. A request reads one node per tree
//   level to find the key, then for an insert or remove that changes the
//   set walks back to the root, with extra node reads and writes at a level
//   that needs a single or a double rotation. With 256 keys the tree has at
//   most 11 levels. The pace is set by the single node memory: every node
//   visit is one synchronous read.
//   The response sits in an output register, so a new request is taken while
//   the previous response waits; a stalled receiver only holds the block at
//   the end of the following request.
//   Reset (rst, synchronous) empties the set at once: root and counters are
//   cleared, and the node memory needs no clearing since only allocated
//   nodes are ever linked.
// ----------------------------------------------------------------------------
module balanced_ordered_key_set (
  input  logic clk,
  input  logic rst,
  bok_req_if.sink   req,
  bok_rsp_if.source rsp
);

  // Node store and free-node stack.
  bok_pkg::node_t            node_mem [bok_pkg::CAPACITY];
  logic [bok_pkg::IDX_W-1:0] free_mem [bok_pkg::CAPACITY];

  bok_pkg::state_t state, state_next;

  logic                          mem_re;
  logic [bok_pkg::IDX_W-1:0]     mem_raddr;
  logic                          mem_we;
  logic [bok_pkg::IDX_W-1:0]     mem_waddr;
  bok_pkg::node_t                mem_wdata;
  bok_pkg::node_t                rd;
  logic                          fs_re;
  logic                          fs_we;
  logic [bok_pkg::IDX_W-1:0]     fs_rdata;

  logic [1:0]                    act;
  logic [bok_pkg::KEY_BITS-1:0]  key_q;
  logic [bok_pkg::LINK_W-1:0]    cur;
  logic                          present;
  logic                          refused;
  logic                          rep_mode;
  logic [bok_pkg::LINK_W-1:0]    tgt_idx;
  logic [bok_pkg::KEY_BITS-1:0]  rep_key;
  logic [bok_pkg::LINK_W-1:0]    sub;
  logic [bok_pkg::HGT_W-1:0]     sub_h;
  logic [bok_pkg::LINK_W-1:0]    root;
  logic [bok_pkg::COUNT_W-1:0]   count;
  logic [bok_pkg::LINK_W-1:0]    fresh;
  logic [bok_pkg::LINK_W-1:0]    fs_sp;
  logic [bok_pkg::LINK_W-1:0]    nidx;

  logic [bok_pkg::LINK_W-1:0]    path_node [bok_pkg::PATH_DEPTH];
  logic                          path_dir  [bok_pkg::PATH_DEPTH];
  logic [bok_pkg::PATH_SP_W-1:0] sp;
  logic [bok_pkg::PATH_IDX_W-1:0] top;

  // Working registers of the walk back to the root.
  logic [bok_pkg::LINK_W-1:0]    xi, yi, zi, oth;
  bok_pkg::node_t                x, y, z;
  logic                          d, s;
  logic [bok_pkg::HGT_W-1:0]     hlight, h_outer, h_inner, h_za, h_zb;

  // Combinational helpers.
  logic                          key_lt, key_eq;
  logic [bok_pkg::HGT_W-1:0]     h_o, hl, hr, bal_h, hx_s, hy_s, hx_d, hy_d;
  logic                          heavy_l, heavy_r;
  bok_pkg::node_t                x_rd;
  logic [bok_pkg::LINK_W-1:0]    del_child;

  assign top     = bok_pkg::PATH_IDX_W'(sp - 1'b1);
  assign key_lt  = key_q < rd.key;
  assign key_eq  = key_q == rd.key;
  assign h_o     = bok_pkg::hgt_of(oth, rd);
  assign hl      = d ? h_o : sub_h;
  assign hr      = d ? sub_h : h_o;
  assign heavy_l = hl > (hr + 1'b1);
  assign heavy_r = hr > (hl + 1'b1);
  assign bal_h   = bok_pkg::hnext(hl, hr);
  assign hx_s    = bok_pkg::hnext(h_inner, hlight);
  assign hy_s    = bok_pkg::hnext(h_outer, hx_s);
  assign hy_d    = bok_pkg::hnext(h_outer, h_za);
  assign hx_d    = bok_pkg::hnext(h_zb, hlight);

  // The node popped from the path takes the predecessor key if it is the one
  // whose key was removed with two children.
  always_comb begin
    x_rd = rd;
    if (rep_mode && (xi == tgt_idx)) begin
      x_rd.key = rep_key;
    end
  end

  // One-child removal splices in the child (or null when there is none).
  assign del_child = (x.left == bok_pkg::NULL_LINK) ? x.right : x.left;

  // Memories.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd <= node_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (fs_we) begin
      free_mem[fs_sp[bok_pkg::IDX_W-1:0]] <= (state == bok_pkg::ST_REM) ?
        xi[bok_pkg::IDX_W-1:0] : cur[bok_pkg::IDX_W-1:0];
    end
    if (fs_re) begin
      fs_rdata <= free_mem[bok_pkg::IDX_W'(fs_sp - 1'b1)];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      bok_pkg::ST_IDLE: begin
        if (req.valid) state_next = bok_pkg::ST_DESC;
      end
      bok_pkg::ST_DESC: begin
        if (cur != bok_pkg::NULL_LINK) begin
          state_next = bok_pkg::ST_DESC_W;
        end else if (act == bok_pkg::ACT_INSERT &&
                     count != bok_pkg::COUNT_W'(bok_pkg::CAPACITY)) begin
          state_next = bok_pkg::ST_ALLOC;
        end else begin
          state_next = bok_pkg::ST_FIN;
        end
      end
      bok_pkg::ST_DESC_W: begin
        if (key_eq) begin
          state_next = (act == bok_pkg::ACT_REMOVE) ? bok_pkg::ST_REM : bok_pkg::ST_FIN;
        end else begin
          state_next = bok_pkg::ST_DESC;
        end
      end
      bok_pkg::ST_REM: begin
        if (x.left == bok_pkg::NULL_LINK || x.right == bok_pkg::NULL_LINK) begin
          state_next = bok_pkg::ST_UP;
        end else begin
          state_next = bok_pkg::ST_PRED;
        end
      end
      bok_pkg::ST_PRED:   state_next = bok_pkg::ST_PRED_W;
      bok_pkg::ST_PRED_W: begin
        state_next = (rd.right == bok_pkg::NULL_LINK) ? bok_pkg::ST_UP : bok_pkg::ST_PRED;
      end
      bok_pkg::ST_ALLOC: begin
        state_next = (fs_sp != '0) ? bok_pkg::ST_ALLOC_W : bok_pkg::ST_ALLOC_WR;
      end
      bok_pkg::ST_ALLOC_W:  state_next = bok_pkg::ST_ALLOC_WR;
      bok_pkg::ST_ALLOC_WR: state_next = bok_pkg::ST_UP;
      bok_pkg::ST_UP: begin
        state_next = (sp == '0) ? bok_pkg::ST_FIN : bok_pkg::ST_UP_X;
      end
      bok_pkg::ST_UP_X: state_next = bok_pkg::ST_UP_O;
      bok_pkg::ST_UP_O: begin
        state_next = (heavy_l || heavy_r) ? bok_pkg::ST_RB_Y : bok_pkg::ST_UP;
      end
      bok_pkg::ST_RB_Y:  state_next = bok_pkg::ST_RB_YO;
      bok_pkg::ST_RB_YO: state_next = bok_pkg::ST_RB_YI;
      bok_pkg::ST_RB_YI: begin
        state_next = (h_outer >= bok_pkg::hgt_of(bok_pkg::child_of(y, !s), rd)) ?
                     bok_pkg::ST_RB_S1 : bok_pkg::ST_RB_ZA;
      end
      bok_pkg::ST_RB_S1: state_next = bok_pkg::ST_RB_S2;
      bok_pkg::ST_RB_S2: state_next = bok_pkg::ST_UP;
      bok_pkg::ST_RB_ZA: state_next = bok_pkg::ST_RB_ZB;
      bok_pkg::ST_RB_ZB: state_next = bok_pkg::ST_RB_D1;
      bok_pkg::ST_RB_D1: state_next = bok_pkg::ST_RB_D2;
      bok_pkg::ST_RB_D2: state_next = bok_pkg::ST_RB_D3;
      bok_pkg::ST_RB_D3: state_next = bok_pkg::ST_UP;
      bok_pkg::ST_FIN: begin
        if (!rsp.valid || rsp.ready) state_next = bok_pkg::ST_IDLE;
      end
      default: state_next = bok_pkg::ST_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    req.ready = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = x;
    fs_re     = 1'b0;
    fs_we     = 1'b0;
    case (state)
      bok_pkg::ST_IDLE: req.ready = 1'b1;
      bok_pkg::ST_DESC, bok_pkg::ST_PRED: begin
        mem_re    = 1'b1;
        mem_raddr = cur[bok_pkg::IDX_W-1:0];
      end
      bok_pkg::ST_REM: begin
        fs_we = (x.left == bok_pkg::NULL_LINK || x.right == bok_pkg::NULL_LINK);
      end
      bok_pkg::ST_PRED_W: fs_we = (rd.right == bok_pkg::NULL_LINK);
      bok_pkg::ST_ALLOC:  fs_re = (fs_sp != '0);
      bok_pkg::ST_ALLOC_WR: begin
        mem_we    = 1'b1;
        mem_waddr = nidx[bok_pkg::IDX_W-1:0];
        mem_wdata = '{key: key_q, left: bok_pkg::NULL_LINK, right: bok_pkg::NULL_LINK,
                      height: bok_pkg::HGT_W'(1)};
      end
      bok_pkg::ST_UP: begin
        mem_re    = (sp != '0);
        mem_raddr = path_node[top][bok_pkg::IDX_W-1:0];
      end
      bok_pkg::ST_UP_X: begin
        mem_re    = 1'b1;
        mem_raddr = bok_pkg::child_addr(rd, !d);
      end
      bok_pkg::ST_UP_O: begin
        if (heavy_l || heavy_r) begin
          mem_re    = 1'b1;
          mem_raddr = bok_pkg::child_addr(x, heavy_r);
        end else begin
          mem_we    = 1'b1;
          mem_waddr = xi[bok_pkg::IDX_W-1:0];
          mem_wdata = x;
          mem_wdata.height = bal_h;
        end
      end
      bok_pkg::ST_RB_Y: begin
        mem_re    = 1'b1;
        mem_raddr = bok_pkg::child_addr(rd, s);
      end
      bok_pkg::ST_RB_YO: begin
        mem_re    = 1'b1;
        mem_raddr = bok_pkg::child_addr(y, !s);
      end
      bok_pkg::ST_RB_YI: begin
        mem_re    = 1'b1;
        mem_raddr = bok_pkg::child_addr(rd, s);
      end
      bok_pkg::ST_RB_ZA: begin
        mem_re    = 1'b1;
        mem_raddr = bok_pkg::child_addr(z, !s);
      end
      bok_pkg::ST_RB_S1: begin
        mem_we    = 1'b1;
        mem_waddr = xi[bok_pkg::IDX_W-1:0];
        mem_wdata = bok_pkg::with_child(x, s, bok_pkg::child_of(y, !s));
        mem_wdata.height = hx_s;
      end
      bok_pkg::ST_RB_S2: begin
        mem_we    = 1'b1;
        mem_waddr = yi[bok_pkg::IDX_W-1:0];
        mem_wdata = bok_pkg::with_child(y, !s, xi);
        mem_wdata.height = hy_s;
      end
      bok_pkg::ST_RB_D1: begin
        mem_we    = 1'b1;
        mem_waddr = yi[bok_pkg::IDX_W-1:0];
        mem_wdata = bok_pkg::with_child(y, !s, bok_pkg::child_of(z, s));
        mem_wdata.height = hy_d;
      end
      bok_pkg::ST_RB_D2: begin
        mem_we    = 1'b1;
        mem_waddr = xi[bok_pkg::IDX_W-1:0];
        mem_wdata = bok_pkg::with_child(x, s, bok_pkg::child_of(z, !s));
        mem_wdata.height = hx_d;
      end
      bok_pkg::ST_RB_D3: begin
        mem_we    = 1'b1;
        mem_waddr = zi[bok_pkg::IDX_W-1:0];
        mem_wdata = bok_pkg::with_child(bok_pkg::with_child(z, s, yi), !s, xi);
        mem_wdata.height = bok_pkg::hnext(hy_d, hx_d);
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bok_pkg::ST_IDLE;
      root      <= bok_pkg::NULL_LINK;
      count     <= '0;
      fresh     <= '0;
      fs_sp     <= '0;
      sp        <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        bok_pkg::ST_IDLE: begin
          if (req.valid) sp <= '0;
        end
        bok_pkg::ST_DESC_W: begin
          if (!key_eq) sp <= sp + 1'b1;
        end
        bok_pkg::ST_REM: begin
          if (x.left == bok_pkg::NULL_LINK || x.right == bok_pkg::NULL_LINK) begin
            fs_sp <= fs_sp + 1'b1;
          end else begin
            sp <= sp + 1'b1;
          end
        end
        bok_pkg::ST_PRED_W: begin
          if (rd.right == bok_pkg::NULL_LINK) begin
            fs_sp <= fs_sp + 1'b1;
          end else begin
            sp <= sp + 1'b1;
          end
        end
        bok_pkg::ST_ALLOC: begin
          if (fs_sp == '0) fresh <= fresh + 1'b1;
        end
        bok_pkg::ST_ALLOC_W: fs_sp <= fs_sp - 1'b1;
        bok_pkg::ST_UP: begin
          if (sp == '0) begin
            root <= sub;
          end else begin
            sp <= sp - 1'b1;
          end
        end
        bok_pkg::ST_FIN: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            if (act == bok_pkg::ACT_INSERT && !present && !refused) begin
              count <= count + 1'b1;
            end else if (act == bok_pkg::ACT_REMOVE && present) begin
              count <= count - 1'b1;
            end
          end
        end
        default: ;
      endcase
      if (state != bok_pkg::ST_FIN && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    case (state)
      bok_pkg::ST_IDLE: begin
        act      <= req.action;
        key_q    <= {~req.key[bok_pkg::KEY_BITS-1], req.key[bok_pkg::KEY_BITS-2:0]};
        cur      <= root;
        rep_mode <= 1'b0;
        present  <= 1'b0;
        refused  <= 1'b0;
      end
      bok_pkg::ST_DESC: begin
        if (cur == bok_pkg::NULL_LINK) begin
          refused <= (act == bok_pkg::ACT_INSERT) &&
                     (count == bok_pkg::COUNT_W'(bok_pkg::CAPACITY));
        end
      end
      bok_pkg::ST_DESC_W: begin
        if (key_eq) begin
          present <= 1'b1;
          x       <= rd;
          xi      <= cur;
        end else begin
          path_node[sp[bok_pkg::PATH_IDX_W-1:0]] <= cur;
          path_dir[sp[bok_pkg::PATH_IDX_W-1:0]]  <= !key_lt;
          cur <= key_lt ? rd.left : rd.right;
        end
      end
      bok_pkg::ST_REM: begin
        if (x.left == bok_pkg::NULL_LINK || x.right == bok_pkg::NULL_LINK) begin
          sub   <= del_child;
          sub_h <= (del_child == bok_pkg::NULL_LINK) ? '0 : bok_pkg::HGT_W'(1);
        end else begin
          // Two children: the largest key on the left takes this node's place.
          path_node[sp[bok_pkg::PATH_IDX_W-1:0]] <= xi;
          path_dir[sp[bok_pkg::PATH_IDX_W-1:0]]  <= 1'b0;
          rep_mode <= 1'b1;
          tgt_idx  <= xi;
          cur      <= x.left;
        end
      end
      bok_pkg::ST_PRED_W: begin
        if (rd.right == bok_pkg::NULL_LINK) begin
          rep_key <= rd.key;
          sub     <= rd.left;
          sub_h   <= (rd.left == bok_pkg::NULL_LINK) ? '0 : bok_pkg::HGT_W'(1);
        end else begin
          path_node[sp[bok_pkg::PATH_IDX_W-1:0]] <= cur;
          path_dir[sp[bok_pkg::PATH_IDX_W-1:0]]  <= 1'b1;
          cur <= rd.right;
        end
      end
      bok_pkg::ST_ALLOC: begin
        if (fs_sp == '0) nidx <= fresh;
      end
      bok_pkg::ST_ALLOC_W: nidx <= bok_pkg::LINK_W'(fs_rdata);
      bok_pkg::ST_ALLOC_WR: begin
        sub   <= nidx;
        sub_h <= bok_pkg::HGT_W'(1);
      end
      bok_pkg::ST_UP: begin
        xi <= path_node[top];
        d  <= path_dir[top];
      end
      bok_pkg::ST_UP_X: begin
        x   <= bok_pkg::with_child(x_rd, d, sub);
        oth <= bok_pkg::child_of(rd, !d);
      end
      bok_pkg::ST_UP_O: begin
        s      <= heavy_r;
        hlight <= heavy_r ? hl : hr;
        yi     <= bok_pkg::child_of(x, heavy_r);
        sub    <= xi;
        sub_h  <= bal_h;
      end
      bok_pkg::ST_RB_Y: y <= rd;
      bok_pkg::ST_RB_YO: h_outer <= bok_pkg::hgt_of(bok_pkg::child_of(y, s), rd);
      bok_pkg::ST_RB_YI: begin
        h_inner <= bok_pkg::hgt_of(bok_pkg::child_of(y, !s), rd);
        z       <= rd;
        zi      <= bok_pkg::child_of(y, !s);
      end
      bok_pkg::ST_RB_S2: begin
        sub   <= yi;
        sub_h <= hy_s;
      end
      bok_pkg::ST_RB_ZA: h_za <= bok_pkg::hgt_of(bok_pkg::child_of(z, s), rd);
      bok_pkg::ST_RB_ZB: h_zb <= bok_pkg::hgt_of(bok_pkg::child_of(z, !s), rd);
      bok_pkg::ST_RB_D3: begin
        sub   <= zi;
        sub_h <= bok_pkg::hnext(hy_d, hx_d);
      end
      bok_pkg::ST_FIN: begin
        if (!rsp.valid || rsp.ready) begin
          rsp.was_present  <= present;
          rsp.changed      <= (act == bok_pkg::ACT_INSERT && !present && !refused) ||
                              (act == bok_pkg::ACT_REMOVE && present);
          rsp.full_refused <= refused;
          if (act == bok_pkg::ACT_INSERT && !present && !refused) begin
            rsp.element_count <= count + 1'b1;
          end else if (act == bok_pkg::ACT_REMOVE && present) begin
            rsp.element_count <= count - 1'b1;
          end else begin
            rsp.element_count <= count;
          end
        end
      end
      default: ;
    endcase
  end

endmodule
